// ===== design/scdf_pkg.sv =====
`timescale 1ns / 1ps
// types and constants for the signature framed command deframer
// no dependencies
package scdf_pkg;

  localparam logic [7:0] SIG_A = 8'h41;
  localparam logic [7:0] SIG_R = 8'h52;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam logic [7:0] SIG_C = 8'h43;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_R    = 3'd1,
    PH_M    = 3'd2,
    PH_C    = 3'd3,
    PH_HDR  = 3'd4,
    PH_PAY  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DROP = 2'd0,
    KIND_SIG  = 2'd1,
    KIND_HDR  = 2'd2,
    KIND_PAY  = 2'd3
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t kind;
    logic [7:0] position;
    logic [7:0] byte_value;
    logic       frame_done;
    logic [7:0] payload_length;
    logic       length_out_of_range;
  } result_t;

endpackage

// ===== design/scdf_in_stage.sv =====
`timescale 1ns / 1ps
// input register for received bytes
// depends on nothing but the handshake from the top level
module scdf_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== design/scdf_parser.sv =====
`timescale 1ns / 1ps
// frame parsing state machine: signature hunt, header, length latch, payload
// uses scdf_pkg
module scdf_parser import scdf_pkg::*; #(
  parameter int HEADER_LEN    = 16,
  parameter int LENGTH_OFFSET = 5,
  parameter int MAX_PAYLOAD   = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] header_count, header_count_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] length_latch, length_latch_next;

  logic [7:0] hc_inc;
  logic [7:0] pc_inc;
  logic       len_hit;
  logic       len_ok;
  logic [7:0] want;

  assign hc_inc  = header_count + 8'd1;
  assign pc_inc  = payload_count + 8'd1;
  assign len_hit = (phase == PH_HDR) && (header_count == 8'(LENGTH_OFFSET));
  assign length_latch_next = len_hit ? rx_byte : length_latch;
  assign len_ok  = (length_latch_next != 8'd0) &&
                   (length_latch_next <= 8'(MAX_PAYLOAD));

  always_comb begin
    case (phase)
      PH_R:    want = SIG_R;
      PH_M:    want = SIG_M;
      default: want = SIG_C;
    endcase
  end

  // next state
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    payload_count_next = payload_count;
    case (phase)
      PH_R, PH_M, PH_C: begin
        if (rx_byte == want) begin
          phase_next        = phase_t'(phase + 3'd1);
          header_count_next = {5'd0, phase} + 8'd1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_HDR: begin
        header_count_next = hc_inc;
        if (hc_inc >= 8'(HEADER_LEN)) begin
          if (len_ok) begin
            payload_count_next = 8'd0;
            phase_next         = PH_PAY;
          end else begin
            header_count_next = 8'd0;
            phase_next        = PH_HUNT;
          end
        end
      end
      PH_PAY: begin
        payload_count_next = pc_inc;
        if (pc_inc >= length_latch) begin
          payload_count_next = 8'd0;
          phase_next         = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (rx_byte == SIG_A) begin
          header_count_next = 8'd1;
          phase_next        = PH_R;
        end
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res                     = '0;
    res.kind                = KIND_DROP;
    res.byte_value          = rx_byte;
    res.payload_length      = length_latch_next;
    case (phase)
      PH_R, PH_M, PH_C: begin
        if (rx_byte == want) begin
          res.kind     = KIND_SIG;
          res.position = {5'd0, phase};
        end
      end
      PH_HDR: begin
        res.kind     = KIND_HDR;
        res.position = header_count;
        if (hc_inc >= 8'(HEADER_LEN) && !len_ok) begin
          res.frame_done          = 1'b1;
          res.length_out_of_range = 1'b1;
        end
      end
      PH_PAY: begin
        res.kind       = KIND_PAY;
        res.position   = payload_count;
        res.frame_done = (pc_inc >= length_latch);
      end
      default: begin
        if (rx_byte == SIG_A) begin
          res.kind = KIND_SIG;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_count  <= 8'd0;
      payload_count <= 8'd0;
      length_latch  <= 8'd0;
    end else if (advance) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      payload_count <= payload_count_next;
      length_latch  <= length_latch_next;
    end
  end

`ifndef SYNTHESIS
  a_done_to_hunt: assert property (@(posedge clk) disable iff (rst)
    advance && res.frame_done |=> phase == PH_HUNT)
    else $error("frame end did not return to hunting");

  a_sig_to_header: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_C && res.kind == KIND_SIG |=>
      phase == PH_HDR && header_count == 8'd4)
    else $error("full signature did not open the header");

  a_pay_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> payload_count < length_latch && length_latch != 8'd0)
    else $error("payload count beyond latched length");

  a_hdr_done_oor: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_HDR && res.frame_done |-> res.length_out_of_range
      && !len_ok)
    else $error("header frame end without out of range length");
`endif

endmodule

// ===== design/scdf_out_stage.sv =====
`timescale 1ns / 1ps
// result register toward the output channel
// uses scdf_pkg
module scdf_out_stage import scdf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= res;
    end
  end

endmodule

// ===== design/signature_framed_command_deframer.sv =====
`timescale 1ns / 1ps
// Deframer for byte streams framed by the signature A,R,M,C, a fixed-length
// header carrying a length byte, and a payload of that length. One byte is
// accepted per cycle unless out_ready stalls the result register, and every
// byte yields one tagged result via the input register and then the result
// register; the rate is set by the single parse state machine between them,
// which updates once per byte. A length of zero or above MAX_PAYLOAD ends the
// frame on its last header byte with the out-of-range flag. Uses scdf_pkg.
module signature_framed_command_deframer import scdf_pkg::*; #(
  parameter int HEADER_LEN    = 16,
  parameter int LENGTH_OFFSET = 5,
  parameter int MAX_PAYLOAD   = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] byte_kind,
  output logic [7:0] position,
  output logic [7:0] byte_value,
  output logic       frame_done,
  output logic [7:0] payload_length,
  output logic       length_out_of_range
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  result_t    res;
  result_t    res_q;

  assign advance = held_valid && can_load;

  scdf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  scdf_parser #(
    .HEADER_LEN    (HEADER_LEN),
    .LENGTH_OFFSET (LENGTH_OFFSET),
    .MAX_PAYLOAD   (MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (held_byte),
    .res     (res)
  );

  scdf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (res_q)
  );

  assign byte_kind           = res_q.kind;
  assign position            = res_q.position;
  assign byte_value          = res_q.byte_value;
  assign frame_done          = res_q.frame_done;
  assign payload_length      = res_q.payload_length;
  assign length_out_of_range = res_q.length_out_of_range;

endmodule

// ===== bench/tb_signature_framed_command_deframer.sv =====
`timescale 1ns / 1ps
// testbench for signature_framed_command_deframer: directed and random byte streams
// with a behavioral predictor and a scoreboard; depends on scdf_pkg and the design
module tb_signature_framed_command_deframer import scdf_pkg::*;;

  localparam int HDR_LEN     = 16;
  localparam int LEN_OFS     = 5;
  localparam int MAX_PAY     = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] byte_kind;
  logic [7:0] position;
  logic [7:0] byte_value;
  logic       frame_done;
  logic [7:0] payload_length;
  logic       length_out_of_range;

  // predictor state
  phase_t     pred_phase;
  logic [7:0] pred_hdr_cnt;
  logic [7:0] pred_pay_cnt;
  logic [7:0] pred_len_latch;

  result_t    expected_results[$];
  int         fail_count;
  int         sent_count;
  int         cycle_count;
  bit         feed_burst;
  bit         drain_burst;

  signature_framed_command_deframer #(
    .HEADER_LEN   (HDR_LEN),
    .LENGTH_OFFSET(LEN_OFS),
    .MAX_PAYLOAD  (MAX_PAY)
  ) i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .byte_kind          (byte_kind),
    .position           (position),
    .byte_value         (byte_value),
    .frame_done         (frame_done),
    .payload_length     (payload_length),
    .length_out_of_range(length_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] want;
    r.kind                = KIND_DROP;
    r.position            = 8'd0;
    r.byte_value          = b;
    r.frame_done          = 1'b0;
    r.length_out_of_range = 1'b0;
    case (pred_phase)
      PH_R, PH_M, PH_C: begin
        want = (pred_phase == PH_R) ? SIG_R : (pred_phase == PH_M) ? SIG_M : SIG_C;
        if (b == want) begin
          r.kind       = KIND_SIG;
          r.position   = {5'd0, pred_phase};
          pred_hdr_cnt = {5'd0, pred_phase} + 8'd1;
          pred_phase   = phase_t'(pred_phase + 3'd1);
        end else begin
          pred_phase = PH_HUNT;
        end
      end
      PH_HDR: begin
        r.kind     = KIND_HDR;
        r.position = pred_hdr_cnt;
        if (pred_hdr_cnt == 8'(LEN_OFS)) pred_len_latch = b;
        pred_hdr_cnt = pred_hdr_cnt + 8'd1;
        if (pred_hdr_cnt >= 8'(HDR_LEN)) begin
          if (pred_len_latch >= 8'd1 && pred_len_latch <= 8'(MAX_PAY)) begin
            pred_pay_cnt = 8'd0;
            pred_phase   = PH_PAY;
          end else begin
            r.frame_done          = 1'b1;
            r.length_out_of_range = 1'b1;
            pred_hdr_cnt          = 8'd0;
            pred_phase            = PH_HUNT;
          end
        end
      end
      PH_PAY: begin
        r.kind       = KIND_PAY;
        r.position   = pred_pay_cnt;
        pred_pay_cnt = pred_pay_cnt + 8'd1;
        if (pred_pay_cnt >= pred_len_latch) begin
          pred_pay_cnt = 8'd0;
          r.frame_done = 1'b1;
          pred_phase   = PH_HUNT;
        end
      end
      default: begin
        pred_phase = PH_HUNT;
        if (b == SIG_A) begin
          r.kind       = KIND_SIG;
          pred_hdr_cnt = 8'd1;
          pred_phase   = PH_R;
        end
      end
    endcase
    r.payload_length = pred_len_latch;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = feed_burst ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    expected_results.push_back(deframe_byte(b));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] len_byte);
    send_byte(SIG_A);
    send_byte(SIG_R);
    send_byte(SIG_M);
    send_byte(SIG_C);
    for (int p = 4; p < HDR_LEN; p++) begin
      if (p == LEN_OFS) send_byte(len_byte);
      else send_byte(8'($urandom_range(0, 255)));
    end
    if (len_byte >= 8'd1 && len_byte <= 8'(MAX_PAY)) begin
      repeat (len_byte) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // signature cut short after 1 to 3 good bytes by a wrong one
  task automatic send_broken_signature();
    int unsigned good;
    logic [7:0]  sig [4];
    logic [7:0]  bad;
    sig[0] = SIG_A;
    sig[1] = SIG_R;
    sig[2] = SIG_M;
    sig[3] = SIG_C;
    good = $urandom_range(1, 3);
    for (int i = 0; i < good; i++) send_byte(sig[i]);
    bad = ($urandom_range(0, 1) == 0) ? SIG_A : 8'($urandom_range(0, 255));
    if (bad == sig[good]) bad = ~bad;
    send_byte(bad);
  endtask

  task automatic test_signature_hunt();
    feed_burst  = 1'b1;
    drain_burst = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SIG_R);
    send_byte(SIG_A);
    send_byte(SIG_A);
    send_byte(SIG_R);
    send_byte(SIG_A);
    send_byte(SIG_R);
    send_byte(SIG_C);
    send_byte(SIG_A);
    send_byte(SIG_R);
    send_byte(SIG_M);
    send_byte(SIG_A);
    feed_burst  = 1'b0;
    drain_burst = 1'b0;
    wait_drained();
  endtask

  task automatic test_out_of_range_frame();
    send_frame(8'hFF);
    wait_drained();
  endtask

  task automatic test_length_extremes();
    send_frame(8'd0);
    send_frame(8'd1);
    feed_burst = 1'b1;
    send_frame(8'(MAX_PAY));
    feed_burst  = 1'b0;
    drain_burst = 1'b1;
    send_frame(8'(MAX_PAY + 1));
    send_frame(8'd1);
    drain_burst = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_stream();
    int          stop_at;
    int          pause_at;
    bit          paused;
    int unsigned pick;
    logic [7:0]  len_byte;
    stop_at  = sent_count + 900;
    pause_at = sent_count + 450;
    paused   = 1'b0;
    while (sent_count < stop_at) begin
      feed_burst  = ($urandom_range(0, 3) == 0);
      drain_burst = ($urandom_range(0, 3) == 0);
      if (!paused && sent_count >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        send_broken_signature();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) len_byte = 8'($urandom_range(1, 8));
        else if (pick < 75) len_byte = 8'($urandom_range(9, MAX_PAY));
        else if (pick < 78) len_byte = 8'(MAX_PAY);
        else if (pick < 84) len_byte = 8'd1;
        else if (pick < 90) len_byte = 8'd0;
        else if (pick < 96) len_byte = 8'($urandom_range(MAX_PAY + 1, 254));
        else len_byte = 8'hFF;
        send_frame(len_byte);
      end
    end
    feed_burst  = 1'b0;
    drain_burst = 1'b0;
  endtask

  // result side stall
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = drain_burst ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual kind %0d value %0d",
                 $time, byte_kind, byte_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("byte_kind", int'(want.kind), int'(byte_kind));
        check_field("position", int'(want.position), int'(position));
        check_field("byte_value", int'(want.byte_value), int'(byte_value));
        check_field("frame_done", int'(want.frame_done), int'(frame_done));
        check_field("payload_length", int'(want.payload_length), int'(payload_length));
        check_field("length_out_of_range", int'(want.length_out_of_range),
                    int'(length_out_of_range));
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = 8'h00;
    feed_burst     = 1'b0;
    drain_burst    = 1'b0;
    fail_count     = 0;
    sent_count     = 0;
    pred_phase     = PH_HUNT;
    pred_hdr_cnt   = 8'd0;
    pred_pay_cnt   = 8'd0;
    pred_len_latch = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_signature_hunt();
    test_out_of_range_frame();
    test_length_extremes();
    test_random_stream();
    wait_drained();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
